### sv/hhca_pkg.sv
package hhca_pkg;

  // Hue scale: degrees with 8 fractional bits.
  localparam logic [16:0] HUE_SIXTY = 17'd15360;
  localparam logic [16:0] HUE_120   = 17'd30720;
  localparam logic [16:0] HUE_240   = 17'd61440;
  localparam logic [16:0] HUE_FULL  = 17'd92160;

  // Unity for saturation and lightness (0.16 fractions).
  localparam logic [16:0] ONE16 = 17'd65536;

  // Pipeline geometry.
  localparam int DIV_STAGES = 17;
  localparam int PIPE_DEPTH = 28;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_HUE   = 2'd1;
  localparam logic [1:0] CFG_SAT   = 2'd2;
  localparam logic [1:0] CFG_LIGHT = 2'd3;

  // Hue base codes (which channel was the maximum).
  localparam logic [1:0] BASE_RED   = 2'd0;
  localparam logic [1:0] BASE_GREEN = 2'd1;
  localparam logic [1:0] BASE_BLUE  = 2'd2;

  // Per-channel mix codes for the back conversion.
  localparam logic [1:0] MIX_ZERO = 2'd0;
  localparam logic [1:0] MIX_PART = 2'd1;
  localparam logic [1:0] MIX_FULL = 2'd2;

  // One slice of the restoring divider.
  typedef struct packed {
    logic [8:0]  rem;
    logic [16:0] bits;
    logic [8:0]  den;
    logic [16:0] quo;
  } div_t;

  // Side data that travels alongside the divider.
  typedef struct packed {
    logic [16:0] light;
    logic        neg;
    logic [1:0]  base;
    logic        chroma_nz;
  } side_t;

  // Load a 26-bit numerator; the quotient is known to fit in 17 bits.
  function automatic div_t div_init(logic [25:0] num, logic [8:0] den);
    div_t x;
    x.rem  = num[25:17];
    x.bits = num[16:0];
    x.den  = den;
    x.quo  = '0;
    return x;
  endfunction

  // Produce one quotient bit.
  function automatic div_t div_step(div_t x);
    div_t       y;
    logic [9:0] t;
    y = x;
    t = {x.rem, x.bits[16]};
    y.bits = {x.bits[15:0], 1'b0};
    if (t >= {1'b0, x.den}) begin
      y.rem = 9'(t - {1'b0, x.den});
      y.quo = {x.quo[15:0], 1'b1};
    end else begin
      y.rem = t[8:0];
      y.quo = {x.quo[15:0], 1'b0};
    end
    return y;
  endfunction

  // Multiply by 15360 (2^14 - 2^10).
  function automatic logic [47:0] times_sixty(logic [33:0] x);
    return {x, 14'd0} - {4'd0, x, 10'd0};
  endfunction

  // Mix codes {red, green, blue} for a hue sector.
  function automatic logic [5:0] sector_mix(logic [2:0] sector);
    logic [5:0] m;
    case (sector)
      3'd0:    m = {MIX_FULL, MIX_PART, MIX_ZERO};
      3'd1:    m = {MIX_PART, MIX_FULL, MIX_ZERO};
      3'd2:    m = {MIX_ZERO, MIX_FULL, MIX_PART};
      3'd3:    m = {MIX_ZERO, MIX_PART, MIX_FULL};
      3'd4:    m = {MIX_PART, MIX_ZERO, MIX_FULL};
      default: m = {MIX_FULL, MIX_ZERO, MIX_PART};
    endcase
    return m;
  endfunction

endpackage

### sv/hsl_hsv_color_adjust.sv
// Each start transfer yields one out_valid strobe when its pixel leaves the pipeline.
// Throughput: one pixel per cycle; busy is never raised and nothing stalls.
// The depth is set by the 17-stage restoring dividers for hue and saturation.
// Synchronous active-low reset clears the configuration registers and the
// valid bits; data registers are not reset. Results cannot be held off.
module hsl_hsv_color_adjust (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  output logic       out_valid,
  output logic [7:0] out_red_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_blue_out,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int DS = hhca_pkg::DIV_STAGES;
  localparam int PD = hhca_pkg::PIPE_DEPTH;

  // Configuration registers.
  logic       hsl_mode_r;
  logic [8:0] hue_offset_r;
  logic [8:0] sat_offset_r;
  logic [8:0] light_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hsl_mode_r     <= 1'b0;
      hue_offset_r   <= '0;
      sat_offset_r   <= '0;
      light_offset_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hhca_pkg::CFG_MODE:  hsl_mode_r     <= cfg_data[0];
        hhca_pkg::CFG_HUE:   hue_offset_r   <= cfg_data;
        hhca_pkg::CFG_SAT:   sat_offset_r   <= cfg_data;
        hhca_pkg::CFG_LIGHT: light_offset_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Every cycle can take a pixel.
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Valid bits, one per pipeline stage.
  logic [PD-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PD-2:0], accept};
    end
  end
  assign out_valid = vld_r[PD-1];

  // Stage A: capture the pixel.
  logic [7:0] a_r_r, a_g_r, a_b_r;
  always_ff @(posedge clk) begin
    a_r_r <= in_red_in;
    a_g_r <= in_green_in;
    a_b_r <= in_blue_in;
  end

  // Stage B: max, min, chroma and the hue numerator.
  logic [7:0] b_mx_nxt, b_mn_nxt, b_num_nxt, b_dd_nxt;
  logic       b_neg_nxt;
  logic [1:0] b_base_nxt;
  logic [8:0] b_sum_nxt, b_inv_nxt;
  logic [7:0] b_mx_r, b_c_r, b_num_r, b_dd_r;
  logic [8:0] b_sum_r;
  logic       b_neg_r;
  logic [1:0] b_base_r;

  always_comb begin
    b_mx_nxt = (a_r_r > a_g_r) ? a_r_r : a_g_r;
    b_mn_nxt = (a_r_r < a_g_r) ? a_r_r : a_g_r;
    if (a_b_r > b_mx_nxt) b_mx_nxt = a_b_r;
    if (a_b_r < b_mn_nxt) b_mn_nxt = a_b_r;
    if (b_mx_nxt == a_r_r) begin
      b_neg_nxt  = a_g_r < a_b_r;
      b_num_nxt  = b_neg_nxt ? a_b_r - a_g_r : a_g_r - a_b_r;
      b_base_nxt = hhca_pkg::BASE_RED;
    end else if (b_mx_nxt == a_g_r) begin
      b_neg_nxt  = a_b_r < a_r_r;
      b_num_nxt  = b_neg_nxt ? a_r_r - a_b_r : a_b_r - a_r_r;
      b_base_nxt = hhca_pkg::BASE_GREEN;
    end else begin
      b_neg_nxt  = a_r_r < a_g_r;
      b_num_nxt  = b_neg_nxt ? a_g_r - a_r_r : a_r_r - a_g_r;
      b_base_nxt = hhca_pkg::BASE_BLUE;
    end
    b_sum_nxt = {1'b0, b_mx_nxt} + {1'b0, b_mn_nxt};
    b_inv_nxt = 9'd510 - b_sum_nxt;
    if (!hsl_mode_r) begin
      b_dd_nxt = b_mx_nxt;
    end else if (b_sum_nxt < b_inv_nxt) begin
      b_dd_nxt = b_sum_nxt[7:0];
    end else begin
      b_dd_nxt = b_inv_nxt[7:0];
    end
  end

  always_ff @(posedge clk) begin
    b_mx_r   <= b_mx_nxt;
    b_c_r    <= b_mx_nxt - b_mn_nxt;
    b_num_r  <= b_num_nxt;
    b_neg_r  <= b_neg_nxt;
    b_base_r <= b_base_nxt;
    b_sum_r  <= b_sum_nxt;
    b_dd_r   <= b_dd_nxt;
  end

  // Stage C: divider operands and the unadjusted lightness or value.
  logic [15:0] c_v;
  logic [16:0] c_vq;
  logic [16:0] c_light_nxt;
  logic [25:0] c_nh_r, c_ns_r;
  logic [8:0]  c_dh_r, c_ds_r;
  hhca_pkg::side_t c_side_r;

  always_comb begin
    c_v  = {b_sum_r, 7'd0} + 16'd127;
    c_vq = 17'(c_v) + 17'(c_v[15:8]) + 17'd1;
    if (!hsl_mode_r) begin
      c_light_nxt = 17'({b_mx_r, 8'd0}) + 17'(b_mx_r) + 17'(b_mx_r[7]);
    end else begin
      c_light_nxt = 17'({b_sum_r, 7'd0}) + 17'(c_vq[16:8]);
    end
  end

  always_ff @(posedge clk) begin
    c_nh_r <= 26'({b_num_r, 15'd0}) - 26'({b_num_r, 11'd0}) + 26'(b_c_r);
    c_dh_r <= {b_c_r, 1'b0};
    c_ns_r <= 26'({b_c_r, 17'd0}) + 26'(b_dd_r);
    c_ds_r <= {b_dd_r, 1'b0};
    c_side_r.light     <= c_light_nxt;
    c_side_r.neg       <= b_neg_r;
    c_side_r.base      <= b_base_r;
    c_side_r.chroma_nz <= b_c_r != 8'd0;
  end

  // Divider stages: one quotient bit each for hue and saturation.
  hhca_pkg::div_t  dh_r [DS];
  hhca_pkg::div_t  ds_r [DS];
  hhca_pkg::side_t sd_r [DS];

  always_ff @(posedge clk) begin
    dh_r[0] <= hhca_pkg::div_step(hhca_pkg::div_init(c_nh_r, c_dh_r));
    ds_r[0] <= hhca_pkg::div_step(hhca_pkg::div_init(c_ns_r, c_ds_r));
    sd_r[0] <= c_side_r;
    for (int i = 1; i < DS; i++) begin
      dh_r[i] <= hhca_pkg::div_step(dh_r[i-1]);
      ds_r[i] <= hhca_pkg::div_step(ds_r[i-1]);
      sd_r[i] <= sd_r[i-1];
    end
  end

  // Stage E1: apply the offsets.
  logic signed [18:0] e1_hoff, e1_soff, e1_loff, e1_base, e1_q;
  logic signed [18:0] e1_h_r, e1_s_r, e1_l_r;
  hhca_pkg::side_t    e1_side;

  always_comb begin
    e1_side = sd_r[DS-1];
    e1_hoff = {{2{hue_offset_r[8]}}, hue_offset_r, 8'd0};
    e1_soff = {sat_offset_r[8], sat_offset_r, 9'd0};
    e1_loff = {light_offset_r[8], light_offset_r, 9'd0};
    case (e1_side.base)
      hhca_pkg::BASE_GREEN: e1_base = {2'd0, hhca_pkg::HUE_120};
      hhca_pkg::BASE_BLUE:  e1_base = {2'd0, hhca_pkg::HUE_240};
      default:              e1_base = '0;
    endcase
    e1_q = {2'd0, dh_r[DS-1].quo};
  end

  always_ff @(posedge clk) begin
    if (!e1_side.chroma_nz) begin
      e1_h_r <= e1_hoff;
      e1_s_r <= '0;
    end else begin
      e1_h_r <= (e1_side.neg ? e1_base - e1_q : e1_base + e1_q) + e1_hoff;
      e1_s_r <= $signed({2'd0, ds_r[DS-1].quo}) + e1_soff;
    end
    e1_l_r <= $signed({2'd0, e1_side.light}) + e1_loff;
  end

  // Stage E2: wrap the hue once and clamp S and L/V to 0..1.
  logic signed [18:0] e2_full, e2_one;
  logic [16:0] e2_h_r, e2_s_r, e2_l_r;

  always_comb begin
    e2_full = {2'd0, hhca_pkg::HUE_FULL};
    e2_one  = {2'd0, hhca_pkg::ONE16};
  end

  always_ff @(posedge clk) begin
    if (e1_h_r < 0) begin
      e2_h_r <= 17'(e1_h_r + e2_full);
    end else if (e1_h_r >= e2_full) begin
      e2_h_r <= 17'(e1_h_r - e2_full);
    end else begin
      e2_h_r <= e1_h_r[16:0];
    end
    if (e1_s_r < 0) begin
      e2_s_r <= '0;
    end else if (e1_s_r > e2_one) begin
      e2_s_r <= hhca_pkg::ONE16;
    end else begin
      e2_s_r <= e1_s_r[16:0];
    end
    if (e1_l_r < 0) begin
      e2_l_r <= '0;
    end else if (e1_l_r > e2_one) begin
      e2_l_r <= hhca_pkg::ONE16;
    end else begin
      e2_l_r <= e1_l_r[16:0];
    end
  end

  // Stage F: hue sector, ramp weight and the chroma multiplier.
  logic [1:0]  f_pair;
  logic [16:0] f_f;
  logic        f_hi;
  logic [2:0]  f_sector_r;
  logic [13:0] f_w_r;
  logic [16:0] f_s_r, f_l_r, f_m_r;

  always_comb begin
    if (e2_h_r >= hhca_pkg::HUE_240) begin
      f_pair = 2'd2;
      f_f    = e2_h_r - hhca_pkg::HUE_240;
    end else if (e2_h_r >= hhca_pkg::HUE_120) begin
      f_pair = 2'd1;
      f_f    = e2_h_r - hhca_pkg::HUE_120;
    end else begin
      f_pair = 2'd0;
      f_f    = e2_h_r;
    end
    f_hi = f_f >= hhca_pkg::HUE_SIXTY;
  end

  always_ff @(posedge clk) begin
    f_sector_r <= {f_pair, f_hi};
    f_w_r      <= f_hi ? 14'(hhca_pkg::HUE_120 - f_f) : f_f[13:0];
    f_s_r      <= e2_s_r;
    f_l_r      <= e2_l_r;
    if (!hsl_mode_r) begin
      f_m_r <= e2_l_r;
    end else if (e2_l_r[16:15] != 2'd0) begin
      f_m_r <= 17'({hhca_pkg::ONE16, 1'b0} - {e2_l_r, 1'b0});
    end else begin
      f_m_r <= {e2_l_r[15:0], 1'b0};
    end
  end

  // Stage G: product of multiplier and saturation.
  logic [33:0] g_ms_r;
  logic [13:0] g_w_r;
  logic [2:0]  g_sector_r;
  logic [16:0] g_l_r;

  always_ff @(posedge clk) begin
    g_ms_r     <= f_m_r * f_s_r;
    g_w_r      <= f_w_r;
    g_sector_r <= f_sector_r;
    g_l_r      <= f_l_r;
  end

  // Stage H: ramp product and the common base level.
  logic [47:0] h_msw_r;
  logic [33:0] h_b_r, h_g_r;
  logic [2:0]  h_sector_r;
  logic [33:0] h_g;

  assign h_g = {g_ms_r[32:0], 1'b0};

  always_ff @(posedge clk) begin
    h_msw_r    <= g_ms_r * g_w_r;
    h_g_r      <= h_g;
    h_b_r      <= {g_l_r, 17'd0} - (hsl_mode_r ? g_ms_r : h_g);
    h_sector_r <= g_sector_r;
  end

  // Stage I: channel values at scale 2^33 * 15360.
  logic [5:0]  i_mix;
  logic [47:0] i_base, i_part, i_full;
  logic [47:0] i_val_nxt [3];
  logic [47:0] i_val_r   [3];

  always_comb begin
    i_mix  = hhca_pkg::sector_mix(h_sector_r);
    i_base = hhca_pkg::times_sixty(h_b_r);
    i_part = {h_msw_r[46:0], 1'b0};
    i_full = hhca_pkg::times_sixty(h_g_r);
    for (int ch = 0; ch < 3; ch++) begin
      case (i_mix[2*(2-ch) +: 2])
        hhca_pkg::MIX_PART: i_val_nxt[ch] = i_base + i_part;
        hhca_pkg::MIX_FULL: i_val_nxt[ch] = i_base + i_full;
        default:            i_val_nxt[ch] = i_base;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      i_val_r[ch] <= i_val_nxt[ch];
    end
  end

  // Stage J: scale by 255, add half, drop the power-of-two part of the divisor.
  logic [55:0] j_y [3];
  logic [11:0] j_x_r [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      j_y[ch] = {i_val_r[ch], 8'd0} - {8'd0, i_val_r[ch]} + (56'd15 << 42);
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      j_x_r[ch] <= j_y[ch][54:43];
    end
  end

  // Stage K: divide by 15 through a reciprocal and clamp to 8 bits.
  logic [25:0] k_p [3];
  logic [7:0]  k_pix [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      k_p[ch]   = 26'({1'b0, j_x_r[ch]} + 13'd1) * 26'd4369;
      k_pix[ch] = (k_p[ch][25:24] != 2'd0) ? 8'd255 : k_p[ch][23:16];
    end
  end

  always_ff @(posedge clk) begin
    out_red_out   <= k_pix[0];
    out_green_out <= k_pix[1];
    out_blue_out  <= k_pix[2];
  end

  // Every accepted pixel yields exactly one result.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##28 out_valid)
    else $error("accepted pixel produced no result");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 28))
    else $error("result without an accepted pixel");

  // The wrapped hue stays below a full turn.
  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[21] |-> e2_h_r < hhca_pkg::HUE_FULL)
    else $error("hue wrap out of range");

  // The reciprocal stage never sees more than 255.5 times 15.
  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[26] |-> (j_x_r[0] <= 12'd3832 && j_x_r[1] <= 12'd3832 && j_x_r[2] <= 12'd3832))
    else $error("scaled channel value out of range");

endmodule
